// ----- rtl/tagged_block_pool_allocator_top_assert.svh -----
// Assertion macros shared by the allocator modules.
// Both expect ports named clock and reset in the module that uses them.
`ifndef TAGGED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define TAGGED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TBPA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tbpa: assertion failed");

// next-cycle implication
`define TBPA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tbpa: assertion failed");

`endif

// ----- rtl/tbpa_pkg.sv -----
package tbpa_pkg;

   localparam int BLOCKS = 64;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int CHAN_W = 5;
   localparam int TAG_W  = 3;

   localparam logic [CNT_W-1:0] BLOCKS_CNT     = CNT_W'(BLOCKS);
   localparam logic [31:0]      BLOCK_SIZE_RST = 32'd32768;
   localparam logic [CNT_W-1:0] MIN_BLOCKS_RST = 7'd12;

   localparam logic [2:0] FUNC_RESERVE = 3'd0;
   localparam logic [2:0] FUNC_RELEASE = 3'd1;
   localparam logic [2:0] FUNC_LIST    = 3'd2;
   localparam logic [2:0] FUNC_FREE    = 3'd3;
   localparam logic [2:0] FUNC_REINIT  = 3'd4;

   localparam logic [TAG_W-1:0] TAG_NONE     = 3'd0;
   localparam logic [TAG_W-1:0] TAG_ADC      = 3'd1;
   localparam logic [TAG_W-1:0] TAG_DAC      = 3'd2;
   localparam logic [TAG_W-1:0] TAG_GPIO     = 3'd3;
   localparam logic [TAG_W-1:0] TAG_ADC_SKIP = 3'd4;

   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_SIZE  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;
   localparam logic [1:0] CSR_MIN   = 2'd3;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_TAKE       = 3'd0;
   localparam mode_type MODE_TRIM       = 3'd1;
   localparam mode_type MODE_RELEASE    = 3'd2;
   localparam mode_type MODE_COUNT_TAG  = 3'd3;
   localparam mode_type MODE_LIST       = 3'd4;
   localparam mode_type MODE_COUNT_FREE = 3'd5;

   typedef logic [1:0] res_type;
   localparam res_type RES_ZERO = 2'd0;
   localparam res_type RES_GOT  = 2'd1;
   localparam res_type RES_FAIL = 2'd2;
   localparam res_type RES_SIZE = 2'd3;

   typedef struct packed {
      logic     load;
      logic     walk_init;
      logic     clr_cnt;
      logic     walk;
      mode_type mode;
      logic     emit;
      res_type  res_sel;
      logic     reinit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       chans_zero;
      logic       walk_done;
      logic       out_free;
      logic       min_fail;
      logic       cnt_zero;
      logic       reinit_fail;
   } sts_type;

endpackage

// ----- rtl/tbpa_datapath.sv -----
`include "tagged_block_pool_allocator_top_assert.svh"

module tbpa_datapath
   import tbpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_func,
   input  logic [TAG_W-1:0]    req_owner_tag,
   input  logic [CNT_W-1:0]    req_block_request,
   input  logic [CHAN_W-1:0]   req_channel_count,
   input  logic                csr_wr,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_status,
   output logic [CNT_W-1:0]    rsp_count,
   output logic                rsp_found,
   output logic [IDX_W-1:0]    rsp_block_index,
   output logic [31:0]         rsp_region_start,
   output logic                rsp_last,
   input  cmd_type             cmd,
   output sts_type             sts
);

   logic [31:0]       base_ff, bsize_ff;
   logic [CNT_W-1:0]  bcount_ff, minb_ff;
   logic [2:0]        func_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [CNT_W-1:0]  req_ff;
   logic [CHAN_W-1:0] chans_ff;
   logic [CNT_W-1:0]  table_size_ff;
   logic [CNT_W-1:0]  new_size;

   logic [CNT_W-1:0]  rd_idx_ff;
   logic [31:0]       rd_addr_ff, proc_addr_ff;
   logic              proc_valid_ff;
   logic [IDX_W-1:0]  proc_idx_ff;
   logic [3:0]        tbl_ff [BLOCKS];
   logic [3:0]        rd_data_ff;
   logic              rd_vld_ff;
   logic [BLOCKS-1:0] vld_ff;

   logic [CNT_W-1:0]  got_ff, got_in, k_ff, k_in;
   logic [CHAN_W-1:0] mod_ff, mod_in, mod_inc;

   logic              rsp_valid_ff, rsp_status_ff, rsp_found_ff, rsp_last_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [31:0]       rsp_start_ff;

   logic              rd_more, advance, consume, list_hold, out_free;
   logic              ent_free, match, we, list_emit, emit_any, list_last;
   logic [TAG_W-1:0]  ent_tag;
   logic [3:0]        wdata;
   logic [CNT_W-1:0]  minimum;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         bsize_ff  <= BLOCK_SIZE_RST;
         bcount_ff <= '0;
         minb_ff   <= MIN_BLOCKS_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_BASE:  base_ff   <= csr_data;
            CSR_SIZE:  bsize_ff  <= csr_data;
            CSR_COUNT: bcount_ff <= csr_data[CNT_W-1:0];
            CSR_MIN:   minb_ff   <= csr_data[CNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         tag_ff   <= req_owner_tag;
         req_ff   <= (req_block_request > BLOCKS_CNT) ? BLOCKS_CNT : req_block_request;
         chans_ff <= req_channel_count;
      end
   end

   assign new_size = (bcount_ff > BLOCKS_CNT) ? BLOCKS_CNT : bcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else if (cmd.reinit) begin
         table_size_ff <= new_size;
      end
   end

   // table walk: read one entry ahead, modify the entry behind
   assign rd_more   = rd_idx_ff < table_size_ff;
   assign ent_free  = rd_vld_ff ? rd_data_ff[3]   : 1'b1;
   assign ent_tag   = rd_vld_ff ? rd_data_ff[2:0] : TAG_NONE;
   assign match     = ent_tag == tag_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign list_hold = proc_valid_ff && (cmd.mode == MODE_LIST) && match && !out_free;
   assign advance   = cmd.walk && !cmd.walk_init && !list_hold;
   assign consume   = proc_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff     <= '0;
         proc_valid_ff <= 1'b0;
      end else if (cmd.walk_init) begin
         rd_idx_ff     <= '0;
         proc_valid_ff <= 1'b0;
      end else if (advance) begin
         proc_valid_ff <= rd_more;
         if (rd_more) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         rd_addr_ff <= base_ff;
      end else if (advance && rd_more) begin
         rd_addr_ff   <= rd_addr_ff + bsize_ff;
         proc_addr_ff <= rd_addr_ff;
         proc_idx_ff  <= rd_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         tbl_ff[proc_idx_ff] <= wdata;
      end
      if (advance && rd_more) begin
         rd_data_ff <= tbl_ff[rd_idx_ff[IDX_W-1:0]];
         rd_vld_ff  <= vld_ff[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // entries not yet written since reinit read as free, tag none
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[proc_idx_ff] <= 1'b1;
      end
   end

   assign mod_inc = mod_ff + CHAN_W'(1);

   always_comb begin
      we        = 1'b0;
      wdata     = {1'b1, TAG_NONE};
      got_in    = got_ff;
      mod_in    = mod_ff;
      k_in      = k_ff;
      list_emit = 1'b0;
      if (cmd.walk_init) begin
         k_in = '0;
         if (cmd.clr_cnt) begin
            got_in = '0;
            mod_in = '0;
         end
      end else if (consume) begin
         unique case (cmd.mode)
            MODE_TAKE: begin
               if (ent_free && (got_ff < req_ff)) begin
                  we     = 1'b1;
                  wdata  = {1'b0, tag_ff};
                  got_in = got_ff + CNT_W'(1);
                  mod_in = (mod_inc == chans_ff) ? '0 : mod_inc;
               end
            end
            MODE_TRIM: begin
               if ((mod_ff != '0) && match) begin
                  we     = 1'b1;
                  got_in = got_ff - CNT_W'(1);
                  mod_in = mod_ff - CHAN_W'(1);
               end
            end
            MODE_RELEASE: begin
               we = match;
            end
            MODE_COUNT_TAG: begin
               if (match) begin
                  got_in = got_ff + CNT_W'(1);
               end
            end
            MODE_COUNT_FREE: begin
               if (ent_free) begin
                  got_in = got_ff + CNT_W'(1);
               end
            end
            MODE_LIST: begin
               if (match) begin
                  list_emit = 1'b1;
                  k_in      = k_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         got_ff <= '0;
         mod_ff <= '0;
         k_ff   <= '0;
      end else begin
         got_ff <= got_in;
         mod_ff <= mod_in;
         k_ff   <= k_in;
      end
   end

   // output word register
   assign emit_any  = cmd.emit || list_emit;
   assign list_last = (k_ff + CNT_W'(1)) == got_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_any) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (list_emit) begin
         rsp_status_ff <= 1'b0;
         rsp_count_ff  <= '0;
         rsp_found_ff  <= 1'b1;
         rsp_idx_ff    <= proc_idx_ff;
         rsp_start_ff  <= proc_addr_ff;
         rsp_last_ff   <= list_last;
      end else if (cmd.emit) begin
         rsp_status_ff <= cmd.res_sel == RES_FAIL;
         unique case (cmd.res_sel)
            RES_GOT:  rsp_count_ff <= got_ff;
            RES_SIZE: rsp_count_ff <= new_size;
            default:  rsp_count_ff <= '0;
         endcase
         rsp_found_ff <= 1'b0;
         rsp_idx_ff   <= '0;
         rsp_start_ff <= '0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_block_index  = rsp_idx_ff;
   assign rsp_region_start = rsp_start_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      priority case (tag_ff)
         TAG_ADC, TAG_DAC, TAG_GPIO: minimum = minb_ff;
         TAG_ADC_SKIP:               minimum = CNT_W'(1);
         default:                    minimum = '0;
      endcase
   end

   assign sts.func        = func_ff;
   assign sts.chans_zero  = chans_ff == '0;
   assign sts.walk_done   = !rd_more && !proc_valid_ff;
   assign sts.out_free    = out_free;
   assign sts.min_fail    = minimum > got_ff;
   assign sts.cnt_zero    = got_ff == '0;
   assign sts.reinit_fail = bcount_ff < minb_ff;

   `TBPA_ASSERT_IMP(take_mod_in_range, cmd.walk && (cmd.mode == MODE_TAKE),
                    (chans_ff != '0) && (mod_ff < chans_ff))
   `TBPA_ASSERT_IMP(trim_within_got, cmd.walk && (cmd.mode == MODE_TRIM), mod_ff <= got_ff)
   `TBPA_ASSERT_IMP(proc_in_table, proc_valid_ff, {1'b0, proc_idx_ff} < table_size_ff)

endmodule

// ----- rtl/tbpa_ctrl.sv -----
`include "tagged_block_pool_allocator_top_assert.svh"

module tbpa_ctrl
   import tbpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_TAKE     = 4'd2;
   localparam logic [3:0] S_TRIM     = 4'd3;
   localparam logic [3:0] S_FAIL_REL = 4'd4;
   localparam logic [3:0] S_REL      = 4'd5;
   localparam logic [3:0] S_CNT_TAG  = 4'd6;
   localparam logic [3:0] S_LIST     = 4'd7;
   localparam logic [3:0] S_CNT_FREE = 4'd8;
   localparam logic [3:0] S_RESULT   = 4'd9;
   localparam logic [3:0] S_REINIT   = 4'd10;

   logic [3:0] state_ff, state_in;
   res_type    res_sel_ff, res_sel_in;

   always_comb begin
      cmd         = '0;
      cmd.res_sel = res_sel_ff;
      state_in    = state_ff;
      res_sel_in  = res_sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority case (sts.func)
               FUNC_RESERVE: begin
                  if (sts.chans_zero) begin
                     res_sel_in = RES_ZERO;
                     state_in   = S_RESULT;
                  end else begin
                     cmd.walk_init = 1'b1;
                     cmd.clr_cnt   = 1'b1;
                     state_in      = S_TAKE;
                  end
               end
               FUNC_RELEASE: begin
                  cmd.walk_init = 1'b1;
                  state_in      = S_REL;
               end
               FUNC_LIST: begin
                  cmd.walk_init = 1'b1;
                  cmd.clr_cnt   = 1'b1;
                  state_in      = S_CNT_TAG;
               end
               FUNC_FREE: begin
                  cmd.walk_init = 1'b1;
                  cmd.clr_cnt   = 1'b1;
                  state_in      = S_CNT_FREE;
               end
               FUNC_REINIT: begin
                  state_in = S_REINIT;
               end
               default: begin
                  res_sel_in = RES_ZERO;
                  state_in   = S_RESULT;
               end
            endcase
         end
         S_TAKE: begin
            cmd.walk = 1'b1;
            cmd.mode = MODE_TAKE;
            if (sts.walk_done) begin
               cmd.walk_init = 1'b1;
               state_in      = S_TRIM;
            end
         end
         S_TRIM: begin
            cmd.walk = 1'b1;
            cmd.mode = MODE_TRIM;
            if (sts.walk_done) begin
               if (sts.min_fail) begin
                  cmd.walk_init = 1'b1;
                  state_in      = S_FAIL_REL;
               end else begin
                  res_sel_in = RES_GOT;
                  state_in   = S_RESULT;
               end
            end
         end
         S_FAIL_REL, S_REL: begin
            cmd.walk = 1'b1;
            cmd.mode = MODE_RELEASE;
            if (sts.walk_done) begin
               res_sel_in = RES_ZERO;
               state_in   = S_RESULT;
            end
         end
         S_CNT_TAG: begin
            cmd.walk = 1'b1;
            cmd.mode = MODE_COUNT_TAG;
            if (sts.walk_done) begin
               if (sts.cnt_zero) begin
                  res_sel_in = RES_ZERO;
                  state_in   = S_RESULT;
               end else begin
                  cmd.walk_init = 1'b1;
                  state_in      = S_LIST;
               end
            end
         end
         S_LIST: begin
            cmd.walk = 1'b1;
            cmd.mode = MODE_LIST;
            if (sts.walk_done) begin
               state_in = S_IDLE;
            end
         end
         S_CNT_FREE: begin
            cmd.walk = 1'b1;
            cmd.mode = MODE_COUNT_FREE;
            if (sts.walk_done) begin
               res_sel_in = RES_GOT;
               state_in   = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_REINIT: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = sts.reinit_fail ? RES_FAIL : RES_SIZE;
               cmd.reinit  = !sts.reinit_fail;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         res_sel_ff <= RES_ZERO;
      end else begin
         state_ff   <= state_in;
         res_sel_ff <= res_sel_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   `TBPA_ASSERT_IMP(emit_needs_room, cmd.emit, sts.out_free)
   `TBPA_ASSERT_NXT(load_blocks_input, cmd.load, req_stall)
   `TBPA_ASSERT_IMP(reinit_with_word, cmd.reinit, cmd.emit && !sts.reinit_fail)

endmodule

// ----- rtl/tagged_block_pool_allocator_top.sv -----
// Tagged block pool allocator.
// Request channel (req_*): one word per operation (reserve, release, list
// regions, free count, reinit), taken when req_valid is high and req_stall low.
// Response channel (rsp_*): one word per operation, except list regions,
// which returns one word per block of the tag in index order (one zero-count
// word if none), the final one flagged with rsp_last. The block holds rsp_*
// while rsp_stall is high. Registers (csr_*): base address, block size, block
// count, min blocks, written by index; the user must write them only while no
// operation is in flight, as the block does not enforce it; csr_ready is
// always high. Table passes run on the 64-entry table with one read and one
// write port (read one entry, write back the one before). Reserve is two
// passes, three when the tag minimum fails; release and free count one pass;
// list regions a count pass and, if the count is not zero, a list pass;
// reinit and the other codes none. A stalled response pauses the list pass.
// Reset clears the registers to their defaults and empties the table (size 0);
// reinit rebuilds it at once, all blocks free, unless block count < min blocks.
module tagged_block_pool_allocator_top
   import tbpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [TAG_W-1:0]    req_owner_tag,
   input  logic [CNT_W-1:0]    req_block_request,
   input  logic [CHAN_W-1:0]   req_channel_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_status,
   output logic [CNT_W-1:0]    rsp_count,
   output logic                rsp_found,
   output logic [IDX_W-1:0]    rsp_block_index,
   output logic [31:0]         rsp_region_start,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   tbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tbpa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_owner_tag     (req_owner_tag),
      .req_block_request (req_block_request),
      .req_channel_count (req_channel_count),
      .csr_wr            (csr_wr),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_found         (rsp_found),
      .rsp_block_index   (rsp_block_index),
      .rsp_region_start  (rsp_region_start),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
